>>> rtl/mcr_pkg.sv
// mcr_pkg: shared widths, codes and the step record for the midpoint circle rasterizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mcr_pkg;

	// held center width
	localparam int COORD_BITS = 12;
	// field widths fixed by the stream format
	localparam int IN_COORD_BITS = 12;
	localparam int STEP_BITS     = 11;
	localparam int DEC_BITS      = 15;
	localparam int PIX_BITS      = 14;

	// pixels per step and the index width that walks them
	localparam int PIX_PER_STEP = 8;
	localparam int PIX_IDX_BITS = $clog2(PIX_PER_STEP);

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// input item kind codes
	localparam logic KIND_ADVANCE = 1'b0;
	localparam logic KIND_START   = 1'b1;

	// output tuser bit positions
	localparam int TUSER_COLOR = 0;
	localparam int TUSER_DONE  = 1;

	// one step of the circle as handed from front to back
	typedef struct packed {
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [STEP_BITS-1:0]  x;
		logic [STEP_BITS-1:0]  y;
		logic                  done;
	} step_rec_t;

endpackage

>>> rtl/midpoint_circle_raster_top.sv
// midpoint_circle_raster_top: midpoint circle rasterizer, stream in, stream of pixels out
// depends on mcr_pkg, mcr_front, mcr_queue, mcr_back
`timescale 1ns / 1ps

// A start beat (tuser kind = 1) loads center and radius and emits the eight symmetric
// pixels of the first step; each advance beat (kind = 0) emits the next step, and advance
// beats while no circle is active are taken and dropped. Every emitting beat yields eight
// output beats, one per cycle while m_tready allows, from the back end's single pixel adder
// pair; the front takes a beat in any cycle in which the two-entry step queue has room, so
// up to two steps may be queued behind the one being drawn. The eighth pixel of each step
// carries tlast, and done_res marks the final step.

module midpoint_circle_raster_top import mcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // center_x[11:0], center_y[23:12], radius[34:24], zero pad
	input  logic [0:0]  s_tuser,   // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pixel_x[13:0], pixel_y[27:14], zero pad
	output logic [1:0]  m_tuser,   // color_group[0], done_res[1]
	output logic        m_tlast
);

	logic      fq_valid, fq_ready, qb_valid, qb_ready;
	step_rec_t fq_rec, qb_rec;

	mcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_rec    (fq_rec)
	);

	mcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_rec    (fq_rec),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_rec   (qb_rec)
	);

	mcr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (qb_valid),
		.q_ready  (qb_ready),
		.q_rec    (qb_rec),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> rtl/mcr_front.sv
// mcr_front: accepts start and advance beats, keeps the step state and decision value
// depends on mcr_pkg; feeds step records into mcr_queue
`timescale 1ns / 1ps

module mcr_front import mcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,  // center_x[11:0], center_y[23:12], radius[34:24], zero pad
	input  logic [0:0]       s_tuser,  // kind[0]
	output logic             q_valid,
	input  logic             q_ready,
	output step_rec_t        q_rec
);

	logic [STEP_BITS-1:0]  step_x_q, step_y_q;
	logic [DEC_BITS-1:0]   decision_q;
	logic [COORD_BITS-1:0] held_cx_q, held_cy_q;
	logic                  active_q;

	logic                  accept, start, emit;
	logic [STEP_BITS-1:0]  radius;
	logic [STEP_BITS-1:0]  cur_x, cur_y;
	logic [DEC_BITS-1:0]   cur_d, d_next, diff;
	logic [COORD_BITS-1:0] cur_cx, cur_cy;
	logic [STEP_BITS:0]    x_next;
	logic [STEP_BITS+1:0]  y_next;
	logic                  done;

	// handshake: a beat is taken whenever the queue has room
	assign s_tready = q_ready;
	assign accept   = s_tvalid && s_tready;
	assign start    = (s_tuser[0] == KIND_START);
	assign emit     = accept && (start || active_q);
	assign radius   = s_tdata[34:24];

	// current step: freshly loaded on start, else the held state
	always_comb begin
		if (start) begin
			cur_x  = '0;
			cur_y  = radius;
			cur_d  = DEC_BITS'(3) - DEC_BITS'({radius, 1'b0});
			cur_cx = COORD_BITS'(s_tdata[IN_COORD_BITS-1:0]);
			cur_cy = COORD_BITS'(s_tdata[2*IN_COORD_BITS-1:IN_COORD_BITS]);
		end else begin
			cur_x  = step_x_q;
			cur_y  = step_y_q;
			cur_d  = decision_q;
			cur_cx = held_cx_q;
			cur_cy = held_cy_q;
		end
	end

	// decision update uses x before its increment
	always_comb begin
		diff   = DEC_BITS'(cur_x) - DEC_BITS'(cur_y);
		x_next = {1'b0, cur_x} + 1'b1;
		if (cur_d[DEC_BITS-1]) begin
			d_next = cur_d + DEC_BITS'({cur_x, 2'b00}) + DEC_BITS'(6);
			y_next = {2'b00, cur_y};
		end else begin
			d_next = cur_d + {diff[DEC_BITS-3:0], 2'b00} + DEC_BITS'(10);
			y_next = {2'b00, cur_y} - 1'b1;
		end
		done = $signed({1'b0, x_next}) > $signed(y_next);
	end

	// record of the step whose pixels go out
	always_comb begin
		q_valid    = emit;
		q_rec.cx   = cur_cx;
		q_rec.cy   = cur_cy;
		q_rec.x    = cur_x;
		q_rec.y    = cur_y;
		q_rec.done = done;
	end

	// step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q   <= '0;
			step_y_q   <= '0;
			decision_q <= '0;
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			active_q   <= 1'b0;
		end else if (emit) begin
			step_x_q   <= x_next[STEP_BITS-1:0];
			step_y_q   <= y_next[STEP_BITS-1:0];
			decision_q <= d_next;
			held_cx_q  <= cur_cx;
			held_cy_q  <= cur_cy;
			active_q   <= !done;
		end
	end

endmodule

>>> rtl/mcr_queue.sv
// mcr_queue: short queue of step records between the front and the back
// depends on mcr_pkg
`timescale 1ns / 1ps

module mcr_queue import mcr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  step_rec_t in_rec,
	output logic      out_valid,
	input  logic      out_ready,
	output step_rec_t out_rec
);

	step_rec_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;
	logic                  push, pop;

	assign in_ready  = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_rec   = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/mcr_back.sv
// mcr_back: walks the eight symmetric pixels of each step into the output register
// depends on mcr_pkg; pops step records from mcr_queue
`timescale 1ns / 1ps

module mcr_back import mcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  step_rec_t   q_rec,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // pixel_x[13:0], pixel_y[27:14], zero pad
	output logic [1:0]  m_tuser,  // color_group[0], done_res[1]
	output logic        m_tlast
);

	step_rec_t               rec_q;
	logic                    rec_valid_q;
	logic [PIX_IDX_BITS-1:0] idx_q;
	logic                    m_tvalid_q;
	logic [PIX_BITS-1:0]     px_q, py_q;
	logic                    color_q, last_q, done_q;

	logic                    out_free, adv, last_pix, take;
	logic [PIX_BITS-1:0]     cx, cy, a, b, px, py;
	logic                    px_neg, py_neg;

	assign out_free = !m_tvalid_q || m_tready;
	assign adv      = rec_valid_q && out_free;
	assign last_pix = (idx_q == PIX_IDX_BITS'(PIX_PER_STEP - 1));
	assign q_ready  = !rec_valid_q || (adv && last_pix);
	assign take     = q_valid && q_ready;

	// pixel of the current index: octants swap x and y in the second half
	always_comb begin
		cx = PIX_BITS'(rec_q.cx);
		cy = PIX_BITS'(rec_q.cy);
		a  = idx_q[PIX_IDX_BITS-1] ? PIX_BITS'(rec_q.y) : PIX_BITS'(rec_q.x);
		b  = idx_q[PIX_IDX_BITS-1] ? PIX_BITS'(rec_q.x) : PIX_BITS'(rec_q.y);
		case (idx_q)
			3'd0:    begin px_neg = 1'b0; py_neg = 1'b0; end
			3'd1:    begin px_neg = 1'b1; py_neg = 1'b0; end
			3'd2:    begin px_neg = 1'b0; py_neg = 1'b1; end
			3'd3:    begin px_neg = 1'b1; py_neg = 1'b1; end
			3'd4:    begin px_neg = 1'b0; py_neg = 1'b0; end
			3'd5:    begin px_neg = 1'b0; py_neg = 1'b1; end
			3'd6:    begin px_neg = 1'b1; py_neg = 1'b0; end
			default: begin px_neg = 1'b1; py_neg = 1'b1; end
		endcase
		px = px_neg ? (cx - a) : (cx + a);
		py = py_neg ? (cy - b) : (cy + b);
	end

	// record holder and pixel index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (take) begin
				rec_valid_q <= 1'b1;
			end else if (adv && last_pix) begin
				rec_valid_q <= 1'b0;
			end
			if (adv) begin
				idx_q <= last_pix ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rec_q <= q_rec;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q    <= px;
			py_q    <= py;
			color_q <= idx_q[PIX_IDX_BITS-1];
			last_q  <= last_pix;
			done_q  <= last_pix && rec_q.done;
		end
	end

	assign m_tvalid             = m_tvalid_q;
	assign m_tdata              = {4'b0000, py_q, px_q};
	assign m_tuser[TUSER_COLOR] = color_q;
	assign m_tuser[TUSER_DONE]  = done_q;
	assign m_tlast              = last_q;

	// completion only ever rides on the eighth pixel
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && done_q) |-> last_q)
		else $error("done without last");

	// the index wraps after the eighth pixel
	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_pix) |=> (idx_q == '0))
		else $error("pixel index did not wrap");

	// with no record held the index sits at the first pixel
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!rec_valid_q |-> (idx_q == '0))
		else $error("pixel index moved without a record");

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for the midpoint circle rasterizer, directed table then random
// circles; a local step predictor feeds a queue of expected pixel beats
// depends on mcr_pkg and midpoint_circle_raster_top
`timescale 1ns / 1ps

module tb_top;
	import mcr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 105;
	localparam int HOLD_CYCLES  = 160;
	localparam int DRAIN_CYCLES = 48;

	// one expected or observed pixel beat
	typedef struct packed {
		logic [PIX_BITS-1:0] px;
		logic [PIX_BITS-1:0] py;
		logic                grp;
		logic                last;
		logic                done;
	} pixel_t;

	// how a directed row is checked
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_CENTER} chk_t;

	typedef struct packed {
		logic                     kind;
		logic [IN_COORD_BITS-1:0] cx;
		logic [IN_COORD_BITS-1:0] cy;
		logic [STEP_BITS-1:0]     r;
		chk_t                     chk;
	} stim_row_t;

	localparam int N_ROWS = 25;
	// directed rows: idle advances, zero radius, tiny circles run to completion,
	// corner centers with full radius, restart while drawing, alternating bit patterns
	localparam stim_row_t DIR_ROWS [N_ROWS] = '{
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_NONE},
		'{KIND_START,   12'd0,    12'd0,    11'd0,    CHK_CENTER},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_NONE},
		'{KIND_START,   12'd4095, 12'd4095, 11'd0,    CHK_CENTER},
		'{KIND_START,   12'd2048, 12'd2048, 11'd1,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd4095, 12'd4095, 11'd2047, CHK_NONE},
		'{KIND_START,   12'd0,    12'd0,    11'd2047, CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_START,   12'd4095, 12'd4095, 11'd2047, CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_START,   12'd1365, 12'd2730, 11'd5,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd2730, 12'd1365, 11'd1365, CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_NONE},
		'{KIND_START,   12'd2730, 12'd1365, 11'd1366, CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_START,   12'd100,  12'd200,  11'd3,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_MODEL},
		'{KIND_ADVANCE, 12'd0,    12'd0,    11'd0,    CHK_NONE},
		'{KIND_START,   12'd7,    12'd4088, 11'd1024, CHK_MODEL}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // center_x[11:0], center_y[23:12], radius[34:24], zero pad
	logic [0:0]  s_tuser;   // kind[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // pixel_x[13:0], pixel_y[27:14], zero pad
	logic [1:0]  m_tuser;   // color_group[0], done_res[1]
	logic        m_tlast;

	// circle step predictor state
	logic [STEP_BITS-1:0]       pen_x;
	logic [STEP_BITS-1:0]       pen_y;
	logic signed [DEC_BITS-1:0] dec_val;
	logic [COORD_BITS-1:0]      org_x;
	logic [COORD_BITS-1:0]      org_y;
	logic                       drawing;
	pixel_t                     step_pix [PIX_PER_STEP];

	pixel_t pending_pixels [$];
	int     mismatches  = 0;
	int     live_items  = 0;
	int     cycle_count = 0;
	logic   steady      = 1'b0;
	logic   hold_req    = 1'b0;
	pixel_t seen_pix;
	pixel_t want_pix;

	midpoint_circle_raster_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic pixel_t make_pix(int px, int py, int k);
		pixel_t p;
		p.px   = px[PIX_BITS-1:0];
		p.py   = py[PIX_BITS-1:0];
		p.grp  = (k >= PIX_PER_STEP / 2);
		p.last = (k == PIX_PER_STEP - 1);
		p.done = 1'b0;
		return p;
	endfunction

	// accepted beat: fill step_pix with eight octant pixels, return 8 (0 if dropped)
	function automatic int trace_step(logic kind, logic [IN_COORD_BITS-1:0] cx,
			logic [IN_COORD_BITS-1:0] cy, logic [STEP_BITS-1:0] r);
		int ox;
		int oy;
		int xi;
		int yi;
		int d;
		if (kind == KIND_START) begin
			org_x   = cx;
			org_y   = cy;
			pen_x   = '0;
			pen_y   = r;
			dec_val = DEC_BITS'(3 - 2 * int'(r));
			drawing = 1'b1;
		end else if (!drawing) begin
			return 0;
		end
		ox = int'(org_x);
		oy = int'(org_y);
		xi = int'(pen_x);
		yi = int'(pen_y);
		d  = int'(dec_val);
		step_pix[0] = make_pix(ox + xi, oy + yi, 0);
		step_pix[1] = make_pix(ox - xi, oy + yi, 1);
		step_pix[2] = make_pix(ox + xi, oy - yi, 2);
		step_pix[3] = make_pix(ox - xi, oy - yi, 3);
		step_pix[4] = make_pix(ox + yi, oy + xi, 4);
		step_pix[5] = make_pix(ox + yi, oy - xi, 5);
		step_pix[6] = make_pix(ox - yi, oy + xi, 6);
		step_pix[7] = make_pix(ox - yi, oy - xi, 7);
		// decision update uses x before its increment
		if (d < 0) begin
			d = d + 4 * xi + 6;
		end else begin
			d  = d + 4 * (xi - yi) + 10;
			yi = yi - 1;
		end
		xi = xi + 1;
		dec_val = DEC_BITS'(d);
		pen_x   = STEP_BITS'(xi);
		pen_y   = STEP_BITS'(yi);
		if (xi > yi) begin
			drawing = 1'b0;
			step_pix[PIX_PER_STEP-1].done = 1'b1;
		end
		return PIX_PER_STEP;
	endfunction

	// offer one input beat, wait for the handshake, queue what it should produce
	task automatic send_beat(input logic kind, input logic [IN_COORD_BITS-1:0] cx,
			input logic [IN_COORD_BITS-1:0] cy, input logic [STEP_BITS-1:0] r,
			input chk_t chk);
		int     n;
		int     k;
		pixel_t p;
		while (!steady && $urandom_range(0, 99) < 28) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = {5'd0, r, cy, cx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n = trace_step(kind, cx, cy, r);
		if (chk == CHK_MODEL) begin
			for (k = 0; k < n; k++)
				pending_pixels.push_back(step_pix[k]);
		end else if (chk == CHK_CENTER) begin
			// zero radius: all eight pixels sit on the center, circle done at once
			for (k = 0; k < PIX_PER_STEP; k++) begin
				p = make_pix(int'(cx), int'(cy), k);
				p.done = (k == PIX_PER_STEP - 1);
				pending_pixels.push_back(p);
			end
		end
		if (n > 0)
			live_items++;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// stimulus
	initial begin
		int                       sel;
		logic                     held;
		logic                     paused;
		logic [IN_COORD_BITS-1:0] cx;
		logic [IN_COORD_BITS-1:0] cy;
		held     = 1'b0;
		paused   = 1'b0;
		drawing  = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		arst_n   = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < N_ROWS; i++)
			send_beat(DIR_ROWS[i].kind, DIR_ROWS[i].cx, DIR_ROWS[i].cy, DIR_ROWS[i].r,
				DIR_ROWS[i].chk);

		// random circles, mostly small ones run to completion
		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			steady = (live_items >= 30 && live_items < 55);
			if (!held && live_items >= 65) begin
				held     = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && live_items >= 85) begin
				paused   = 1'b1;
				s_tvalid = 1'b0;
				while (pending_pixels.size() != 0)
					@(negedge clk);
			end
			sel = $urandom_range(0, 99);
			cx  = IN_COORD_BITS'($urandom);
			cy  = IN_COORD_BITS'($urandom);
			if (sel < 70) begin
				send_beat(KIND_START, cx, cy, STEP_BITS'($urandom_range(0, 14)), CHK_MODEL);
				while (drawing && $urandom_range(0, 99) >= 4)
					send_beat(KIND_ADVANCE, IN_COORD_BITS'($urandom),
						IN_COORD_BITS'($urandom), STEP_BITS'($urandom), CHK_MODEL);
				// stray advance, usually after the circle has ended
				if ($urandom_range(0, 3) == 0)
					send_beat(KIND_ADVANCE, cx, cy, STEP_BITS'($urandom), CHK_MODEL);
			end else if (sel < 85) begin
				// large radius, abandoned by the next start
				send_beat(KIND_START, cx, cy, STEP_BITS'($urandom), CHK_MODEL);
				repeat ($urandom_range(0, 4))
					send_beat(KIND_ADVANCE, cx, cy, STEP_BITS'($urandom), CHK_MODEL);
			end else begin
				send_beat(1'($urandom), cx, cy, STEP_BITS'($urandom), CHK_MODEL);
			end
		end
		steady   = 1'b0;
		s_tvalid = 1'b0;

		// drain
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// receiver ready, with one long hold-off on request
	initial begin
		int   hold_cnt;
		logic hold_taken;
		hold_taken = 1'b0;
		m_tready   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready   = 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(negedge clk);
			end
			m_tready = steady || ($urandom_range(0, 99) >= 28);
		end
	end

	// compare each output beat with the oldest expected pixel
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_pix.px   = m_tdata[PIX_BITS-1:0];
			seen_pix.py   = m_tdata[2*PIX_BITS-1:PIX_BITS];
			seen_pix.grp  = m_tuser[TUSER_COLOR];
			seen_pix.done = m_tuser[TUSER_DONE];
			seen_pix.last = m_tlast;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel beat (%0d, %0d)", $signed(seen_pix.px),
					$signed(seen_pix.py));
				mismatches++;
			end else begin
				want_pix = pending_pixels.pop_front();
				check_field("pixel_x", int'($signed(want_pix.px)), int'($signed(seen_pix.px)));
				check_field("pixel_y", int'($signed(want_pix.py)), int'($signed(seen_pix.py)));
				check_field("color_group", int'(want_pix.grp), int'(seen_pix.grp));
				check_field("last", int'(want_pix.last), int'(seen_pix.last));
				check_field("done_res", int'(want_pix.done), int'(seen_pix.done));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
